/* sv/mcmd_pkg.sv */
// Shared types and constants for the MIDI channel message decoder.
// No dependencies.
`default_nettype none

package mcmd_pkg;

	// status nibbles
	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_POLY_AT  = 4'hA;
	localparam logic [3:0] KIND_CC       = 4'hB;
	localparam logic [3:0] KIND_PROGRAM  = 4'hC;
	localparam logic [3:0] KIND_CHAN_AT  = 4'hD;
	localparam logic [3:0] KIND_BEND     = 4'hE;

	localparam logic [7:0] BYTE_SYSEX = 8'hF0;
	localparam logic [7:0] BYTE_EOX   = 8'hF7;

	// controller numbers
	localparam logic [6:0] CC_BANK       = 7'd0;
	localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
	localparam logic [6:0] CC_VOLUME     = 7'd7;
	localparam logic [6:0] CC_PAN        = 7'd10;
	localparam logic [6:0] CC_EXPRESSION = 7'd11;
	localparam logic [6:0] CC_RPN_LSB    = 7'd100;
	localparam logic [6:0] CC_RPN_MSB    = 7'd101;

	localparam logic [6:0] RPN_NULL = 7'd127;

	// per-channel defaults
	localparam logic [6:0]  DEF_BANK       = 7'd0;
	localparam logic [6:0]  DEF_VOLUME     = 7'd100;
	localparam logic [6:0]  DEF_PAN        = 7'd64;
	localparam logic [6:0]  DEF_EXPRESSION = 7'd127;
	localparam logic [6:0]  DEF_BEND_RANGE = 7'd2;
	localparam logic [13:0] DEF_BEND       = 14'd0;
	localparam logic [13:0] BEND_CENTER    = 14'h2000;

	typedef enum logic [2:0] {
		EV_NOTE_ON  = 3'd0,
		EV_NOTE_OFF = 3'd1,
		EV_CC       = 3'd2,
		EV_PROGRAM  = 3'd3,
		EV_BEND     = 3'd4,
		EV_RPN_SET  = 3'd5
	} ev_t;

	typedef enum logic [2:0] {
		CMD_RESET    = 3'd0,
		CMD_NOTE_ON  = 3'd1,
		CMD_NOTE_OFF = 3'd2,
		CMD_CC       = 3'd3,
		CMD_PROGRAM  = 3'd4,
		CMD_BEND     = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] ch;
		logic [6:0] a;
		logic [6:0] b;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/mcmd_front.sv */
// Front end: running-status parser, turns bytes and reset requests into commands.
// Depends on mcmd_pkg.
`default_nettype none

module mcmd_front import mcmd_pkg::*; #(
	parameter int CHANNELS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       action,
	input  wire logic [7:0] data_byte,
	input  wire logic [3:0] reset_channel,
	output cmd_t            cmd,
	output logic            push
);

	logic [7:0] status_q;
	logic [6:0] first_q;
	logic       await_q;
	logic       excl_q;

	logic [7:0] status_d;
	logic [6:0] first_d;
	logic       await_d;
	logic       excl_d;

	logic [3:0] kind;
	logic [3:0] ch;
	logic       ch_ok;
	logic       rch_ok;

	assign kind   = status_q[7:4];
	assign ch     = status_q[3:0];
	assign ch_ok  = {1'b0, ch} < 5'(CHANNELS);
	assign rch_ok = {1'b0, reset_channel} < 5'(CHANNELS);

	always_comb begin
		status_d = status_q;
		first_d  = first_q;
		await_d  = await_q;
		excl_d   = excl_q;
		push     = 1'b0;
		cmd.kind = CMD_RESET;
		cmd.ch   = ch;
		cmd.a    = first_q;
		cmd.b    = data_byte[6:0];
		if (action) begin
			cmd.ch = reset_channel;
			push   = rch_ok;
		end else if (excl_q) begin
			if (data_byte == BYTE_EOX)
				excl_d = 1'b0;
		end else if (data_byte[7]) begin
			if (data_byte == BYTE_SYSEX) begin
				excl_d = 1'b1;
			end else if (data_byte < BYTE_EOX || data_byte == BYTE_EOX) begin
				status_d = data_byte;
				await_d  = 1'b0;
			end
		end else if (await_q) begin
			await_d = 1'b0;
			unique case (kind)
				KIND_NOTE_OFF: begin cmd.kind = CMD_NOTE_OFF; push = ch_ok; end
				KIND_NOTE_ON: begin
					cmd.kind = (data_byte[6:0] != 7'd0) ? CMD_NOTE_ON : CMD_NOTE_OFF;
					push     = ch_ok;
				end
				KIND_CC: begin cmd.kind = CMD_CC; push = ch_ok; end
				KIND_BEND: begin cmd.kind = CMD_BEND; push = ch_ok; end
				default: push = 1'b0;
			endcase
		end else begin
			first_d = data_byte[6:0];
			cmd.a   = data_byte[6:0];
			cmd.b   = 7'd0;
			unique case (kind)
				KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CC, KIND_BEND:
					await_d = 1'b1;
				KIND_PROGRAM: begin cmd.kind = CMD_PROGRAM; push = ch_ok; end
				default: push = 1'b0;   // channel pressure consumed, others ignored
			endcase
		end
		if (!accept)
			push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			first_q  <= '0;
			await_q  <= 1'b0;
			excl_q   <= 1'b0;
		end else if (accept) begin
			status_q <= status_d;
			first_q  <= first_d;
			await_q  <= await_d;
			excl_q   <= excl_d;
		end
	end

endmodule

`default_nettype wire

/* sv/mcmd_fifo.sv */
// Two-entry command queue between parser and executor.
// Depends on mcmd_pkg.
`default_nettype none

module mcmd_fifo import mcmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_cmd,
	input  wire logic pop,
	output cmd_t      rd_cmd,
	output logic      not_empty,
	output logic      not_full
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_empty = count_q != 2'd0;
	assign not_full  = count_q != 2'd2;
	assign rd_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

/* sv/mcmd_back.sv */
// Back end: executes commands against per-channel controller state and
// drives the registered result beat. Depends on mcmd_pkg.
`default_nettype none

module mcmd_back import mcmd_pkg::*; #(
	parameter int CHANNELS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cmd_t         head,
	input  wire logic         head_valid,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              last,
	output logic        [2:0] event_res,
	output logic        [3:0] channel,
	output logic        [6:0] number,
	output logic        [6:0] value,
	output logic signed [13:0] bend,
	output logic        [6:0] bank,
	output logic        [6:0] rpn_lsb,
	output logic        [6:0] volume,
	output logic        [6:0] pan,
	output logic        [6:0] expression,
	output logic        [6:0] bend_range
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [6:0]  rpn_msb_q   [CHANNELS];
	logic [6:0]  rpn_lsb_q   [CHANNELS];
	logic [6:0]  bank_q      [CHANNELS];
	logic [6:0]  volume_q    [CHANNELS];
	logic [6:0]  pan_q       [CHANNELS];
	logic [6:0]  expr_q      [CHANNELS];
	logic [6:0]  brange_q    [CHANNELS];
	logic [13:0] bend_st_q   [CHANNELS];

	logic phase_q;   // second beat of a data entry pending
	logic out_valid_q;
	logic last_q;
	ev_t  ev_q;
	logic [3:0]  ch_q;
	logic [6:0]  number_q, value_q, bank_out_q, rpn_lsb_out_q;
	logic [6:0]  volume_out_q, pan_out_q, expr_out_q, brange_out_q;
	logic [13:0] bend_out_q;

	logic [CH_W-1:0] idx;
	logic            emit_ok, go, is_reset, rpn_hit;
	logic [6:0]      cur_msb, cur_lsb;
	logic [6:0]      n_msb, n_lsb, n_bank, n_vol, n_pan, n_expr, n_br;
	logic [13:0]     n_bend;
	ev_t             ev;
	logic [6:0]      num, val, lsb_o;

	assign idx      = head.ch[CH_W-1:0];
	assign emit_ok  = !out_valid_q || out_ready;
	assign is_reset = head.kind == CMD_RESET;
	assign go       = head_valid && (is_reset || emit_ok);
	assign cur_msb  = rpn_msb_q[idx];
	assign cur_lsb  = rpn_lsb_q[idx];
	assign rpn_hit  = head.kind == CMD_CC && head.a == CC_DATA_ENTRY && !phase_q
		&& cur_msb != RPN_NULL && cur_lsb != RPN_NULL;
	assign pop      = go && !rpn_hit;

	always_comb begin
		n_msb  = cur_msb;
		n_lsb  = cur_lsb;
		n_bank = bank_q[idx];
		n_vol  = volume_q[idx];
		n_pan  = pan_q[idx];
		n_expr = expr_q[idx];
		n_br   = brange_q[idx];
		n_bend = bend_st_q[idx];
		ev     = EV_CC;
		num    = head.a;
		val    = head.b;
		lsb_o  = 7'd0;
		unique case (head.kind)
			CMD_RESET: begin
				n_msb  = RPN_NULL;
				n_lsb  = RPN_NULL;
				n_bank = DEF_BANK;
				n_vol  = DEF_VOLUME;
				n_pan  = DEF_PAN;
				n_expr = DEF_EXPRESSION;
				n_br   = DEF_BEND_RANGE;
				n_bend = DEF_BEND;
			end
			CMD_NOTE_ON: ev = EV_NOTE_ON;
			CMD_NOTE_OFF: begin ev = EV_NOTE_OFF; val = 7'd0; end
			CMD_PROGRAM: begin ev = EV_PROGRAM; val = 7'd0; end
			CMD_BEND: begin
				ev     = EV_BEND;
				num    = 7'd0;
				val    = 7'd0;
				n_bend = {head.b, head.a} ^ BEND_CENTER;
			end
			CMD_CC: begin
				if (rpn_hit) begin
					ev    = EV_RPN_SET;
					num   = cur_msb;
					lsb_o = cur_lsb;
					n_msb = RPN_NULL;
					n_lsb = RPN_NULL;
					if (cur_msb == 7'd0 && cur_lsb == 7'd0)
						n_br = head.b;
				end else if (!phase_q) begin
					unique case (head.a)
						CC_BANK:       n_bank = head.b;
						CC_VOLUME:     n_vol  = head.b;
						CC_PAN:        n_pan  = head.b;
						CC_EXPRESSION: n_expr = head.b;
						CC_RPN_LSB:    n_lsb  = head.b;
						CC_RPN_MSB:    n_msb  = head.b;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rpn_msb_q[i] <= RPN_NULL;
				rpn_lsb_q[i] <= RPN_NULL;
				bank_q[i]    <= DEF_BANK;
				volume_q[i]  <= DEF_VOLUME;
				pan_q[i]     <= DEF_PAN;
				expr_q[i]    <= DEF_EXPRESSION;
				brange_q[i]  <= DEF_BEND_RANGE;
				bend_st_q[i] <= DEF_BEND;
			end
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				rpn_msb_q[idx] <= n_msb;
				rpn_lsb_q[idx] <= n_lsb;
				bank_q[idx]    <= n_bank;
				volume_q[idx]  <= n_vol;
				pan_q[idx]     <= n_pan;
				expr_q[idx]    <= n_expr;
				brange_q[idx]  <= n_br;
				bend_st_q[idx] <= n_bend;
				phase_q        <= rpn_hit;
			end
			if (emit_ok)
				out_valid_q <= go && !is_reset;
		end
	end

	always_ff @(posedge clk) begin
		if (go && !is_reset) begin
			last_q        <= !rpn_hit;
			ev_q          <= ev;
			ch_q          <= head.ch;
			number_q      <= num;
			value_q       <= val;
			rpn_lsb_out_q <= lsb_o;
			bank_out_q    <= n_bank;
			volume_out_q  <= n_vol;
			pan_out_q     <= n_pan;
			expr_out_q    <= n_expr;
			brange_out_q  <= n_br;
			bend_out_q    <= n_bend;
		end
	end

	assign out_valid  = out_valid_q;
	assign last       = last_q;
	assign event_res  = ev_q;
	assign channel    = ch_q;
	assign number     = number_q;
	assign value      = value_q;
	assign bend       = bend_out_q;
	assign bank       = bank_out_q;
	assign rpn_lsb    = rpn_lsb_out_q;
	assign volume     = volume_out_q;
	assign pan        = pan_out_q;
	assign expression = expr_out_q;
	assign bend_range = brange_out_q;

endmodule

`default_nettype wire

/* sv/midi_channel_message_decoder_top.sv */
// MIDI channel message decoder: one byte or channel reset per beat in.
// Throughput: one input beat per cycle while the command FIFO has room. RPN data
// entry gives two results, the RPN set then the control change, from one command.
// A completing byte's command is queued in the FIFO, its result then registered.
// Reset: arst_n clears parser state and loads every channel's defaults at once.
`default_nettype none

module midi_channel_message_decoder_top import mcmd_pkg::*; #(
	parameter int CHANNELS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          action,
	input  wire logic   [7:0]  data_byte,
	input  wire logic   [3:0]  reset_channel,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               last,
	output logic        [2:0]  event_res,
	output logic        [3:0]  channel,
	output logic        [6:0]  number,
	output logic        [6:0]  value,
	output logic signed [13:0] bend,
	output logic        [6:0]  bank,
	output logic        [6:0]  rpn_lsb,
	output logic        [6:0]  volume,
	output logic        [6:0]  pan,
	output logic        [6:0]  expression,
	output logic        [6:0]  bend_range
);

	cmd_t front_cmd, head_cmd;
	logic push, pop, head_valid, not_full, accept;

	assign in_ready = not_full;
	assign accept   = in_valid && not_full;

	mcmd_front #(.CHANNELS(CHANNELS)) u_front (
		.clk, .arst_n, .accept,
		.action, .data_byte, .reset_channel,
		.cmd(front_cmd), .push
	);

	mcmd_fifo u_fifo (
		.clk, .arst_n,
		.push, .wr_cmd(front_cmd),
		.pop, .rd_cmd(head_cmd),
		.not_empty(head_valid), .not_full
	);

	mcmd_back #(.CHANNELS(CHANNELS)) u_back (
		.clk, .arst_n,
		.head(head_cmd), .head_valid, .pop,
		.out_valid, .out_ready,
		.last, .event_res, .channel, .number, .value, .bend, .bank,
		.rpn_lsb, .volume, .pan, .expression, .bend_range
	);

endmodule

`default_nettype wire

/* tb/sv/midi_channel_message_decoder_top_test.sv */
// Self-checking testbench for midi_channel_message_decoder_top.
// Depends on mcmd_pkg and the decoder RTL; holds its own decoder predictor and
// drives MIDI byte streams and channel resets through the valid/ready ports.
`timescale 1ns / 1ps

module midi_channel_message_decoder_top_test import mcmd_pkg::*;;

	localparam int CHANNELS       = 16;
	localparam int RANDOM_ITEMS   = 650;
	localparam int HOLD_AT_ITEM   = 250;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic ACT_BYTE       = 1'b0;
	localparam logic ACT_CHAN_RESET = 1'b1;

	localparam logic [6:0] CC_MODULATION = 7'd1;
	localparam logic [6:0] CC_SUSTAIN    = 7'd64;
	localparam logic [6:0] DATA_MAX      = 7'h7F;

	localparam logic [7:0] BYTE_COMMON_LO = 8'hF1;
	localparam logic [7:0] BYTE_SONG_SEL  = 8'hF3;
	localparam logic [7:0] BYTE_CLOCK     = 8'hF8;
	localparam logic [7:0] BYTE_SYS_RESET = 8'hFF;

	typedef struct packed {
		logic              last;
		ev_t               ev;
		logic [3:0]        ch;
		logic [6:0]        num;
		logic [6:0]        val;
		logic signed [13:0] bend;
		logic [6:0]        bank;
		logic [6:0]        rpn_lsb;
		logic [6:0]        volume;
		logic [6:0]        pan;
		logic [6:0]        expression;
		logic [6:0]        bend_range;
	} midi_event_t;

	class midi_event_scoreboard;
		logic [7:0]  running_status;
		logic [6:0]  first_data;
		bit          await_second;
		bit          in_sysex;
		logic [6:0]  rpn_msb_of [CHANNELS];
		logic [6:0]  rpn_lsb_of [CHANNELS];
		logic [6:0]  bank_of [CHANNELS];
		logic [6:0]  volume_of [CHANNELS];
		logic [6:0]  pan_of [CHANNELS];
		logic [6:0]  expression_of [CHANNELS];
		logic [13:0] bend_of [CHANNELS];
		logic [6:0]  bend_range_of [CHANNELS];
		midi_event_t expected_events [$];
		int          errors;

		function new();
			running_status = '0;
			first_data = '0;
			await_second = 0;
			in_sysex = 0;
			errors = 0;
			for (int c = 0; c < CHANNELS; c++)
				clear_channel(c);
		endfunction

		function void clear_channel(int c);
			rpn_msb_of[c] = RPN_NULL;
			rpn_lsb_of[c] = RPN_NULL;
			bank_of[c] = DEF_BANK;
			volume_of[c] = DEF_VOLUME;
			pan_of[c] = DEF_PAN;
			expression_of[c] = DEF_EXPRESSION;
			bend_of[c] = DEF_BEND;
			bend_range_of[c] = DEF_BEND_RANGE;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		// channel values are snapshotted at the moment the event is formed
		function void add_event(ev_t ev, logic [3:0] ch, logic [6:0] num, logic [6:0] val,
				logic [6:0] lsb);
			midi_event_t e;
			e.last = 1'b0;
			e.ev = ev;
			e.ch = ch;
			e.num = num;
			e.val = val;
			e.bend = bend_of[ch];
			e.bank = bank_of[ch];
			e.rpn_lsb = lsb;
			e.volume = volume_of[ch];
			e.pan = pan_of[ch];
			e.expression = expression_of[ch];
			e.bend_range = bend_range_of[ch];
			expected_events.push_back(e);
		endfunction

		function void decode_message(logic [6:0] b);
			logic [3:0]  ch;
			logic [6:0]  a;
			int          n_before;
			midi_event_t tail;
			ch = running_status[3:0];
			a = first_data;
			n_before = expected_events.size();
			if (ch >= CHANNELS)
				return;
			case (running_status[7:4])
				KIND_NOTE_ON: begin
					if (b != 0)
						add_event(EV_NOTE_ON, ch, a, b, '0);
					else
						add_event(EV_NOTE_OFF, ch, a, '0, '0);
				end
				KIND_NOTE_OFF: add_event(EV_NOTE_OFF, ch, a, '0, '0);
				KIND_CC: begin
					case (a)
						CC_BANK:       bank_of[ch] = b;
						CC_VOLUME:     volume_of[ch] = b;
						CC_PAN:        pan_of[ch] = b;
						CC_EXPRESSION: expression_of[ch] = b;
						CC_RPN_LSB:    rpn_lsb_of[ch] = b;
						CC_RPN_MSB:    rpn_msb_of[ch] = b;
						CC_DATA_ENTRY: begin
							if (rpn_msb_of[ch] != RPN_NULL && rpn_lsb_of[ch] != RPN_NULL) begin
								// RPN 0/0 is pitch bend sensitivity
								if (rpn_msb_of[ch] == 0 && rpn_lsb_of[ch] == 0)
									bend_range_of[ch] = b;
								add_event(EV_RPN_SET, ch, rpn_msb_of[ch], b, rpn_lsb_of[ch]);
								rpn_msb_of[ch] = RPN_NULL;
								rpn_lsb_of[ch] = RPN_NULL;
							end
						end
						default: ;
					endcase
					add_event(EV_CC, ch, a, b, '0);
				end
				KIND_PROGRAM: add_event(EV_PROGRAM, ch, a, '0, '0);
				KIND_BEND: begin
					bend_of[ch] = {b, a} - BEND_CENTER;
					add_event(EV_BEND, ch, '0, '0, '0);
				end
				default: ;
			endcase
			if (expected_events.size() > n_before) begin
				tail = expected_events.pop_back();
				tail.last = 1'b1;
				expected_events.push_back(tail);
			end
		endfunction

		function void track_input(logic act, logic [7:0] b, logic [3:0] rc);
			if (act == ACT_CHAN_RESET) begin
				if (rc < CHANNELS)
					clear_channel(rc);
				return;
			end
			if (in_sysex) begin
				if (b == BYTE_EOX)
					in_sysex = 0;
				return;
			end
			if (b[7]) begin
				if (b > BYTE_EOX)
					return;
				if (b == BYTE_SYSEX) begin
					in_sysex = 1;
					return;
				end
				await_second = 0;
				running_status = b;
				return;
			end
			if (await_second) begin
				await_second = 0;
				decode_message(b[6:0]);
				return;
			end
			first_data = b[6:0];
			case (running_status[7:4])
				KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CC, KIND_BEND: await_second = 1;
				KIND_PROGRAM, KIND_CHAN_AT: decode_message('0);
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int want_v, int got_v);
			if (want_v != got_v) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			end
		endfunction

		function void check_event(midi_event_t got);
			midi_event_t want;
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: event %0d channel %0d number %0d value %0d",
					$time, got.ev, got.ch, got.num, got.val);
				return;
			end
			want = expected_events.pop_front();
			compare_field("last", want.last, got.last);
			compare_field("event_res", want.ev, got.ev);
			compare_field("channel", want.ch, got.ch);
			compare_field("number", want.num, got.num);
			compare_field("value", want.val, got.val);
			compare_field("bend", int'(want.bend), int'(got.bend));
			compare_field("bank", want.bank, got.bank);
			compare_field("rpn_lsb", want.rpn_lsb, got.rpn_lsb);
			compare_field("volume", want.volume, got.volume);
			compare_field("pan", want.pan, got.pan);
			compare_field("expression", want.expression, got.expression);
			compare_field("bend_range", want.bend_range, got.bend_range);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic action = 1'b0;
	logic [7:0] data_byte = '0;
	logic [3:0] reset_channel = '0;
	logic out_ready = 1'b0;

	wire in_ready;
	wire out_valid;
	wire last;
	wire [2:0] event_res;
	wire [3:0] channel;
	wire [6:0] number;
	wire [6:0] value;
	wire signed [13:0] bend;
	wire [6:0] bank;
	wire [6:0] rpn_lsb;
	wire [6:0] volume;
	wire [6:0] pan;
	wire [6:0] expression;
	wire [6:0] bend_range;

	midi_event_scoreboard sb;
	int items_sent = 0;
	int idle_cycles = 0;
	bit calm = 0;
	logic [7:0] sent_status = '0;

	midi_channel_message_decoder_top #(.CHANNELS(CHANNELS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.data_byte(data_byte),
		.reset_channel(reset_channel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.last(last),
		.event_res(event_res),
		.channel(channel),
		.number(number),
		.value(value),
		.bend(bend),
		.bank(bank),
		.rpn_lsb(rpn_lsb),
		.volume(volume),
		.pan(pan),
		.expression(expression),
		.bend_range(bend_range)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [6:0] pick_data();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return DATA_MAX;
		return 7'($urandom_range(0, 127));
	endfunction

	// half the traffic on a few channels so state builds up
	function automatic logic [3:0] pick_channel();
		if ($urandom_range(0, 1))
			return 4'($urandom_range(0, 3));
		return 4'($urandom_range(0, 15));
	endfunction

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_beat(logic act, logic [7:0] b, logic [3:0] rc);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		reset_channel <= rc;
		do
			@(posedge clk);
		while (!in_ready);
		if (act == ACT_CHAN_RESET || b <= BYTE_EOX)
			items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_beat(ACT_BYTE, b, 4'($urandom_range(0, 15)));
	endtask

	// data byte, sometimes preceded by a real-time byte
	task automatic send_data(logic [6:0] d);
		if ($urandom_range(0, 24) == 0)
			send_byte(8'($urandom_range(BYTE_CLOCK, BYTE_SYS_RESET)));
		send_byte({1'b0, d});
	endtask

	task automatic send_status(logic [3:0] kind, logic [3:0] ch);
		if (sent_status != {kind, ch} || $urandom_range(0, 2) == 0)
			send_byte({kind, ch});
		sent_status = {kind, ch};
	endtask

	task automatic send_message();
		int r;
		logic [3:0] ch;
		logic [6:0] ctl;
		r = $urandom_range(0, 99);
		ch = pick_channel();
		if (r < 20) begin
			send_status(KIND_NOTE_ON, ch);
			send_data(pick_data());
			send_data($urandom_range(0, 4) == 0 ? 7'd0 : pick_data());
		end else if (r < 30) begin
			send_status(KIND_NOTE_OFF, ch);
			send_data(pick_data());
			send_data(pick_data());
		end else if (r < 50) begin
			case ($urandom_range(0, 9))
				0: ctl = CC_BANK;
				1: ctl = CC_MODULATION;
				2: ctl = CC_DATA_ENTRY;
				3: ctl = CC_VOLUME;
				4: ctl = CC_PAN;
				5: ctl = CC_EXPRESSION;
				6: ctl = CC_SUSTAIN;
				7: ctl = CC_RPN_LSB;
				8: ctl = CC_RPN_MSB;
				default: ctl = 7'($urandom_range(0, 127));
			endcase
			send_status(KIND_CC, ch);
			send_data(ctl);
			send_data(pick_data());
		end else if (r < 60) begin
			// RPN select then data entry; the msb is sometimes left out
			send_status(KIND_CC, ch);
			if ($urandom_range(0, 3) != 0) begin
				send_data(CC_RPN_MSB);
				send_data($urandom_range(0, 1) ? 7'd0 : pick_data());
			end
			send_data(CC_RPN_LSB);
			send_data($urandom_range(0, 1) ? 7'd0 : pick_data());
			send_data(CC_DATA_ENTRY);
			send_data(pick_data());
			if ($urandom_range(0, 2) == 0) begin
				send_data(CC_DATA_ENTRY);
				send_data(pick_data());
			end
		end else if (r < 66) begin
			send_status(KIND_PROGRAM, ch);
			send_data(pick_data());
		end else if (r < 74) begin
			send_status(KIND_BEND, ch);
			send_data(pick_data());
			send_data(pick_data());
		end else if (r < 78) begin
			send_status(KIND_POLY_AT, ch);
			send_data(pick_data());
			send_data(pick_data());
		end else if (r < 81) begin
			send_status(KIND_CHAN_AT, ch);
			send_data(pick_data());
		end else if (r < 85) begin
			send_byte(BYTE_SYSEX);
			repeat ($urandom_range(0, 6))
				send_byte(8'($urandom_range(0, 255)));
			send_byte(BYTE_EOX);
			sent_status = '0;
		end else if (r < 89) begin
			send_byte(8'($urandom_range(BYTE_COMMON_LO, BYTE_EOX)));
			repeat ($urandom_range(0, 2))
				send_data(pick_data());
			sent_status = '0;
		end else if (r < 92) begin
			send_beat(ACT_CHAN_RESET, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
		end else if (r < 96) begin
			// more data under whatever status is running
			repeat ($urandom_range(1, 3))
				send_data(pick_data());
		end else begin
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)));
			sent_status = '0;
		end
	endtask

	// sink side: random stalls plus one long hold-off to back up the input
	initial begin
		int stall_left;
		int hold_left;
		bit held_once;
		stall_left = 0;
		hold_left = 0;
		held_once = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held_once && items_sent >= HOLD_AT_ITEM) begin
				held_once = 1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm)
					stall_left = pick_gap();
			end
		end
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		midi_event_t seen;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.track_input(action, data_byte, reset_channel);
			if (out_valid && out_ready) begin
				seen.last = last;
				seen.ev = ev_t'(event_res);
				seen.ch = channel;
				seen.num = number;
				seen.val = value;
				seen.bend = bend;
				seen.bank = bank;
				seen.rpn_lsb = rpn_lsb;
				seen.volume = volume;
				seen.pan = pan;
				seen.expression = expression;
				seen.bend_range = bend_range;
				sb.check_event(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("midi_channel_message_decoder_top_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int directed_items;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data with no status yet
		send_byte(8'h45);
		// note on at the extremes, then velocity zero under running status
		send_byte({KIND_NOTE_ON, 4'h0});
		send_byte(8'h00);
		send_byte({1'b0, DATA_MAX});
		send_byte({1'b0, DATA_MAX});
		send_byte(8'h00);
		// RPN 0/0 data entry on the top channel: rpn set plus control change
		send_byte({KIND_CC, 4'hF});
		send_byte({1'b0, CC_RPN_MSB});
		send_byte(8'h00);
		send_byte({1'b0, CC_RPN_LSB});
		send_byte(8'h00);
		send_byte({1'b0, CC_DATA_ENTRY});
		send_byte({1'b0, DATA_MAX});
		// bend extremes, a real-time byte between data bytes
		send_byte({KIND_BEND, 4'hF});
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte({1'b0, DATA_MAX});
		send_byte(BYTE_CLOCK);
		send_byte({1'b0, DATA_MAX});
		// exclusive block swallows a note on
		send_byte(BYTE_SYSEX);
		send_byte({KIND_NOTE_ON, 4'h3});
		send_byte(8'h10);
		send_byte(BYTE_EOX);
		send_byte({KIND_PROGRAM, 4'h3});
		send_byte(8'h05);
		send_byte(BYTE_SONG_SEL);
		send_byte(8'h01);
		send_beat(ACT_CHAN_RESET, 8'h00, 4'hF);
		directed_items = items_sent;

		while (items_sent < directed_items + RANDOM_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				calm = !calm;
			send_message();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("midi_channel_message_decoder_top_test: done, clean");
		else
			$display("midi_channel_message_decoder_top_test: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
sv/mcmd_pkg.sv
sv/mcmd_front.sv
sv/mcmd_fifo.sv
sv/mcmd_back.sv
sv/midi_channel_message_decoder_top.sv
tb/sv/midi_channel_message_decoder_top_test.sv
